[sv/jtp_pkg.sv]
`default_nettype none
package jtp_pkg;

    localparam int JOINTS       = 4;
    localparam int JOINT_W      = 2;
    localparam int ANGLE_W      = 32;
    localparam int LIMIT_W      = 31;
    localparam int DT_W         = 25;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [DT_W-1:0]    DT_DEFAULT   = 25'd16777;
    localparam logic [DT_W-1:0]    DT_MAX       = 25'd16777216;
    localparam logic [31:0]        SETTLE_SPEED = 32'd66;

    localparam logic [LIMIT_W-1:0] VL_RESET   = 31'd205887;
    localparam logic [LIMIT_W-1:0] AL_RESET   = 31'd823550;
    localparam logic [DT_W-1:0]    DT_RESET   = 25'd16777;
    localparam logic [31:0]        ZERO_RESET = 32'd71488;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VEL_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_ZERO  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_STEPPED = 2'd0;
    localparam logic [1:0] ST_SETTLED = 2'd1;
    localparam logic [1:0] ST_HELD    = 2'd2;
    localparam logic [1:0] ST_SEEDED  = 2'd3;

endpackage
`default_nettype wire

[sv/jtp_in_if.sv]
`default_nettype none
interface jtp_in_if import jtp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [JOINT_W-1:0]        joint;
    logic signed [ANGLE_W-1:0] goal_angle;
    logic                      target_valid;
    logic signed [ANGLE_W-1:0] measured_angle;

    modport source (output valid, func, joint, goal_angle, target_valid, measured_angle,
                    input ready);
    modport sink (input valid, func, joint, goal_angle, target_valid, measured_angle,
                  output ready);
endinterface
`default_nettype wire

[sv/jtp_out_if.sv]
`default_nettype none
interface jtp_out_if import jtp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [JOINT_W-1:0]        joint_out;
    logic signed [ANGLE_W-1:0] motor_angle;
    logic signed [ANGLE_W-1:0] profile_angle;
    logic signed [ANGLE_W-1:0] profile_velocity;
    logic signed [ANGLE_W-1:0] profile_accel;
    logic signed [ANGLE_W-1:0] angle_error;
    logic [1:0]                status;

    modport source (output valid, joint_out, motor_angle, profile_angle, profile_velocity,
                    profile_accel, angle_error, status, input ready);
    modport sink (input valid, joint_out, motor_angle, profile_angle, profile_velocity,
                  profile_accel, angle_error, status, output ready);
endinterface
`default_nettype wire

[sv/jtp_cfg_if.sv]
`default_nettype none
interface jtp_cfg_if import jtp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/joint_trapezoid_profile.sv]
`default_nettype none
// Trapezoidal motion profile for four joints, Q16.16 angles and rates.
// Input channel i_in: one item either seeds a joint from its measured angle
// (func = 1), holds it (target_valid = 0) or steps it one time step toward its goal.
// Output channel o_out: exactly one result item per input item, carrying the
// profiled angle, velocity and acceleration, the motor angle and the error.
// Configuration channel i_cfg: writes the speed limit, acceleration limit,
// time step and motor zero angle by index; it is always ready and must only
// be used while no item is in flight.
// Sequencing: a seed item or an item with an invalid target goes from idle
// straight to the final state. A step item passes through VSQ, ERR, DES,
// the one-bit-per-cycle restoring divider DIV that forms the acceleration,
// then ACL, MA, VU, MV, AU and FIN, around a single shared 33 x 32 multiplier
// used four times. A new item is taken only once the last one is through;
// i_in.ready is high only while the sequencer is idle.
// The result sits in an output register. When the receiver stalls, the
// sequencer waits in its final state until the register is free, then
// accepts the next item.
// Reset (synchronous, active low) clears joint state to zero, loads the
// configuration defaults and empties the output register.
module joint_trapezoid_profile import jtp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jtp_in_if.sink     i_in,
    jtp_out_if.source  o_out,
    jtp_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_VSQ, S_ERR, S_DES, S_DIV, S_ACL, S_MA, S_VU, S_MV, S_AU, S_FIN
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [LIMIT_W-1:0]        r_cfg_vl;
    logic [LIMIT_W-1:0]        r_cfg_al;
    logic [DT_W-1:0]           r_cfg_dt;
    logic signed [ANGLE_W-1:0] r_cfg_zero;

    // Joint state.
    logic signed [ANGLE_W-1:0] r_jang [JOINTS];
    logic signed [ANGLE_W-1:0] r_jvel [JOINTS];
    logic signed [ANGLE_W-1:0] r_jacc [JOINTS];

    // Working registers of one item.
    logic [JOINT_W-1:0]        r_joint;
    logic                      r_inrange;
    logic signed [ANGLE_W-1:0] r_target;
    logic signed [ANGLE_W-1:0] r_meas;
    logic signed [ANGLE_W-1:0] r_ang;
    logic signed [ANGLE_W-1:0] r_vel;
    logic signed [ANGLE_W-1:0] r_acc;
    logic signed [32:0]        r_err;
    logic [1:0]                r_status;
    logic [LIMIT_W-1:0]        r_vl;
    logic [LIMIT_W-1:0]        r_al;
    logic [DT_W-1:0]           r_dt;
    logic [64:0]               r_prod;
    logic [64:0]               r_vsq;
    logic [56:0]               r_quo;
    logic [24:0]               r_rem;
    logic                      r_neg;
    logic [5:0]                r_cnt;

    // Output register.
    logic                      r_out_valid;
    logic [JOINT_W-1:0]        r_o_joint;
    logic signed [ANGLE_W-1:0] r_o_motor;
    logic signed [ANGLE_W-1:0] r_o_ang;
    logic signed [ANGLE_W-1:0] r_o_vel;
    logic signed [ANGLE_W-1:0] r_o_acc;
    logic signed [ANGLE_W-1:0] r_o_err;
    logic [1:0]                r_o_status;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        if (x > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // Shared multiplier: its operands follow the sequencer state.
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_VSQ: begin
                mul_a = {1'b0, mag32(r_vel)};
                mul_b = mag32(r_vel);
            end
            S_ERR: begin
                mul_a = r_err[32] ? 33'(-r_err) : 33'(r_err);
                mul_b = {r_al, 1'b0};
            end
            S_MA: begin
                mul_a = {1'b0, mag32(r_acc)};
                mul_b = {7'd0, r_dt};
            end
            S_MV: begin
                mul_a = {1'b0, mag32(r_vel)};
                mul_b = {7'd0, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 65'(mul_a) * 65'(mul_b);
    end

    // Step arithmetic around the shared units.
    logic               moving;
    logic signed [32:0] desired;
    logic signed [33:0] num;
    logic [33:0]        num_mag;
    logic [25:0]        trial;
    logic               trial_ge;
    logic [30:0]        q_clamp;
    logic [32:0]        dt_part;
    logic signed [33:0] vel_sum;
    logic signed [31:0] vel_clamp;
    logic signed [33:0] ang_sum;
    logic signed [32:0] nerr;
    logic               settle;
    logic signed [31:0] fin_ang;
    logic signed [31:0] fin_vel;
    logic signed [31:0] fin_acc;
    logic [1:0]         fin_status;

    always_comb begin
        moving   = (r_err != '0) && (r_prod > r_vsq);
        desired  = !moving ? 33'sd0 :
                   (r_err > 0) ? 33'(signed'({2'b00, r_vl})) : -33'(signed'({2'b00, r_vl}));
        num      = 34'(desired) - 34'(r_vel);
        num_mag  = num[33] ? 34'(-num) : 34'(num);
        trial    = {r_rem, r_quo[56]};
        trial_ge = trial >= {1'b0, r_dt};
        q_clamp  = (r_quo > 57'(r_al)) ? r_al : r_quo[30:0];
        dt_part  = r_prod[56:24];

        vel_sum = r_acc[31] ? 34'(r_vel) - 34'(signed'({1'b0, dt_part}))
                            : 34'(r_vel) + 34'(signed'({1'b0, dt_part}));
        if (vel_sum > 34'(signed'({3'b000, r_vl}))) begin
            vel_clamp = signed'({1'b0, r_vl});
        end else if (vel_sum < -34'(signed'({3'b000, r_vl}))) begin
            vel_clamp = -signed'({1'b0, r_vl});
        end else begin
            vel_clamp = vel_sum[31:0];
        end
        ang_sum = r_vel[31] ? 34'(r_ang) - 34'(signed'({1'b0, dt_part}))
                            : 34'(r_ang) + 34'(signed'({1'b0, dt_part}));

        // The joint settles on overshoot, or on an exact hit at low speed.
        nerr   = 33'(r_target) - 33'(r_ang);
        settle = (r_status == ST_STEPPED) &&
                 (((r_err > 0) && (nerr < 0)) || ((r_err < 0) && (nerr > 0)) ||
                  ((nerr == 0) && (mag32(r_vel) < SETTLE_SPEED)));
        fin_ang    = settle ? r_target : r_ang;
        fin_vel    = settle ? '0 : r_vel;
        fin_acc    = settle ? '0 : r_acc;
        fin_status = settle ? ST_SETTLED : r_status;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.joint_out   = r_o_joint;
    assign o_out.motor_angle = r_o_motor;
    assign o_out.profile_angle    = r_o_ang;
    assign o_out.profile_velocity = r_o_vel;
    assign o_out.profile_accel    = r_o_acc;
    assign o_out.angle_error      = r_o_err;
    assign o_out.status           = r_o_status;

    logic in_range;
    assign in_range = 32'(i_in.joint) < JOINTS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_vl    <= VL_RESET;
            r_cfg_al    <= AL_RESET;
            r_cfg_dt    <= DT_RESET;
            r_cfg_zero  <= signed'(ZERO_RESET);
            for (int i = 0; i < JOINTS; i++) begin
                r_jang[i] <= '0;
                r_jvel[i] <= '0;
                r_jacc[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_VEL_LIMIT:   r_cfg_vl   <= i_cfg.data[LIMIT_W-1:0];
                    REG_ACCEL_LIMIT: r_cfg_al   <= i_cfg.data[LIMIT_W-1:0];
                    REG_TIME_STEP:   r_cfg_dt   <= i_cfg.data[DT_W-1:0];
                    REG_MOTOR_ZERO:  r_cfg_zero <= signed'(i_cfg.data);
                    default: begin
                    end
                endcase
            end
            // In the final state the output register is reloaded instead.
            if (r_out_valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_joint   <= i_in.joint;
                        r_inrange <= in_range;
                        r_target  <= i_in.goal_angle;
                        r_meas    <= i_in.measured_angle;
                        r_vl <= (r_cfg_vl == '0) ? 31'd1 : r_cfg_vl;
                        r_al <= (r_cfg_al == '0) ? 31'd1 : r_cfg_al;
                        r_dt <= (r_cfg_dt == '0) ? DT_DEFAULT :
                                (r_cfg_dt > DT_MAX) ? DT_MAX : r_cfg_dt;
                        r_err <= 33'(i_in.goal_angle) - 33'(r_jang[i_in.joint]);
                        // A seed starts from the measured angle at rest.
                        r_ang <= !in_range ? '0 :
                                 i_in.func ? i_in.measured_angle : r_jang[i_in.joint];
                        r_vel <= (in_range && !i_in.func) ? r_jvel[i_in.joint] : '0;
                        r_acc <= (in_range && !i_in.func) ? r_jacc[i_in.joint] : '0;
                        if (!in_range) begin
                            r_status <= ST_HELD;
                            r_state  <= S_FIN;
                        end else if (i_in.func) begin
                            r_status <= ST_SEEDED;
                            r_state  <= S_FIN;
                        end else if (!i_in.target_valid) begin
                            r_status <= ST_HELD;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_STEPPED;
                            r_state  <= S_VSQ;
                        end
                    end
                end
                S_VSQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_vsq   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_DES;
                end
                S_DES: begin
                    r_neg   <= num[33];
                    r_quo   <= {num_mag[32:0], 24'd0};
                    r_rem   <= '0;
                    r_cnt   <= 6'd57;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= {r_quo[55:0], trial_ge};
                    r_rem <= trial_ge ? 25'(trial - {1'b0, r_dt}) : trial[24:0];
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_ACL;
                    end
                end
                S_ACL: begin
                    r_acc   <= r_neg ? -signed'({1'b0, q_clamp}) : signed'({1'b0, q_clamp});
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_prod  <= mul_p;
                    r_state <= S_VU;
                end
                S_VU: begin
                    r_vel   <= vel_clamp;
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_prod  <= mul_p;
                    r_state <= S_AU;
                end
                S_AU: begin
                    r_ang   <= sat32(ang_sum);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        if (r_inrange) begin
                            r_jang[r_joint] <= fin_ang;
                            r_jvel[r_joint] <= fin_vel;
                            r_jacc[r_joint] <= fin_acc;
                        end
                        r_out_valid <= 1'b1;
                        r_o_joint   <= r_joint;
                        r_o_motor   <= sat32(34'(r_cfg_zero) - 34'(fin_ang));
                        r_o_ang     <= fin_ang;
                        r_o_vel     <= fin_vel;
                        r_o_acc     <= fin_acc;
                        r_o_err     <= sat32(34'(r_meas) - 34'(fin_ang));
                        r_o_status  <= fin_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("block ready right after accepting an item");

    // A result appears only when the sequencer leaves its final state.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_FIN))
        else $error("result produced outside the final state");

    // The clamped acceleration stays within the acceleration limit.
    a_accel_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MA) |-> (mag32(r_acc) <= {1'b0, r_al}))
        else $error("acceleration beyond its limit");

    // The divider never runs with an exhausted bit count.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 6'd0))
        else $error("divider bit count exhausted");

endmodule
`default_nettype wire

[tb/tb_jtp_scoreboard.sv]
`timescale 1ns / 1ps
// One predicted or observed result item.
typedef struct {
    logic [1:0]  joint_out;
    logic [31:0] motor_angle;
    logic [31:0] profile_angle;
    logic [31:0] profile_velocity;
    logic [31:0] profile_accel;
    logic [31:0] angle_error;
    logic [1:0]  status;
} t_profile_result;

// Predicts one result item per input item and compares against the block.
class jtp_scoreboard;
    t_profile_result pending_results[$];
    longint          angle_st[4];
    longint          vel_st[4];
    longint          acc_st[4];
    longint unsigned vel_limit;
    longint unsigned acc_limit;
    longint unsigned step_dt;
    logic [31:0]     zero_angle;
    int              error_count;

    function new();
        int k;
        vel_limit  = 205887;
        acc_limit  = 823550;
        step_dt    = 16777;
        zero_angle = 32'd71488;
        error_count = 0;
        for (k = 0; k < 4; k++) begin
            angle_st[k] = 0;
            vel_st[k] = 0;
            acc_st[k] = 0;
        end
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            jtp_pkg::REG_VEL_LIMIT:   vel_limit = value[30:0];
            jtp_pkg::REG_ACCEL_LIMIT: acc_limit = value[30:0];
            jtp_pkg::REG_TIME_STEP:   step_dt = value[24:0];
            default:                  zero_angle = value;
        endcase
    endfunction

    function longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function longint scale_by_dt(longint x, longint unsigned dt);
        longint unsigned m;
        longint unsigned p;
        m = (x < 0) ? -x : x;
        p = (m * dt) >> 24;
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    function void note_input(logic func, logic [1:0] j, logic [31:0] target_raw,
                             logic target_ok, logic [31:0] meas_raw);
        t_profile_result r;
        longint tgt, meas, vl, al, ang, vel, acc, err, nerr, desired;
        longint unsigned dt, aerr, speed;
        logic [1:0] st;
        tgt  = longint'($signed(target_raw));
        meas = longint'($signed(meas_raw));
        vl = (vel_limit != 0) ? longint'(vel_limit) : 1;
        al = (acc_limit != 0) ? longint'(acc_limit) : 1;
        dt = (step_dt != 0) ? step_dt : 16777;
        if (dt > 16777216) dt = 16777216;
        ang = angle_st[j];
        vel = vel_st[j];
        acc = acc_st[j];
        st = jtp_pkg::ST_HELD;
        if (func) begin
            ang = meas;
            vel = 0;
            acc = 0;
            st = jtp_pkg::ST_SEEDED;
        end else if (target_ok) begin
            err = tgt - ang;
            aerr = (err < 0) ? -err : err;
            speed = (vel < 0) ? -vel : vel;
            desired = 0;
            // Keep cruising at the limit until the stopping distance is reached.
            if (aerr != 0 && aerr * (2 * longint'(al)) > speed * speed)
                desired = (err > 0) ? vl : -vl;
            acc = clamp(((desired - vel) * 64'sd16777216) / longint'(dt), -al, al);
            vel = clamp(vel + scale_by_dt(acc, dt), -vl, vl);
            ang = sat32(ang + scale_by_dt(vel, dt));
            nerr = tgt - ang;
            speed = (vel < 0) ? -vel : vel;
            if ((err > 0 && nerr < 0) || (err < 0 && nerr > 0) ||
                (nerr == 0 && speed < 66)) begin
                ang = tgt;
                vel = 0;
                acc = 0;
                st = jtp_pkg::ST_SETTLED;
            end else begin
                st = jtp_pkg::ST_STEPPED;
            end
        end
        angle_st[j] = ang;
        vel_st[j] = vel;
        acc_st[j] = acc;
        r.joint_out        = j;
        r.motor_angle      = sat32(longint'($signed(zero_angle)) - ang);
        r.profile_angle    = ang;
        r.profile_velocity = vel;
        r.profile_accel    = acc;
        r.angle_error      = sat32(meas - ang);
        r.status           = st;
        pending_results.push_back(r);
    endfunction

    function void check_result(t_profile_result got);
        t_profile_result e;
        if (pending_results.size() == 0) begin
            $error("result item with nothing expected");
            error_count++;
            return;
        end
        e = pending_results.pop_front();
        if (got.joint_out !== e.joint_out) begin
            $error("joint_out expected %0d actual %0d", e.joint_out, got.joint_out);
            error_count++;
        end
        if (got.motor_angle !== e.motor_angle) begin
            $error("motor_angle expected %h actual %h", e.motor_angle, got.motor_angle);
            error_count++;
        end
        if (got.profile_angle !== e.profile_angle) begin
            $error("profile_angle expected %h actual %h", e.profile_angle,
                   got.profile_angle);
            error_count++;
        end
        if (got.profile_velocity !== e.profile_velocity) begin
            $error("profile_velocity expected %h actual %h", e.profile_velocity,
                   got.profile_velocity);
            error_count++;
        end
        if (got.profile_accel !== e.profile_accel) begin
            $error("profile_accel expected %h actual %h", e.profile_accel,
                   got.profile_accel);
            error_count++;
        end
        if (got.angle_error !== e.angle_error) begin
            $error("angle_error expected %h actual %h", e.angle_error, got.angle_error);
            error_count++;
        end
        if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            error_count++;
        end
    endfunction
endclass

[tb/tb_joint_trapezoid_profile.sv]
`timescale 1ns / 1ps
module tb_joint_trapezoid_profile;
    import jtp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    jtp_in_if  in_ch();
    jtp_out_if out_ch();
    jtp_cfg_if cfg_ch();

    joint_trapezoid_profile DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    jtp_scoreboard profile_sb = new();

    // Idle percentages for the sender and the receiver, changed per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // When set, the receiver holds ready low while counting hold_cycles down.
    int hold_cycles = 0;

    // Sets the payload and valid for the next item at a falling edge, then
    // waits for the handshake. Valid stays high into the next item if the
    // sender does not idle, so no drop and raise falls in one time step.
    task automatic send_item(logic func, logic [1:0] j, logic [31:0] tgt,
                             logic tok, logic [31:0] meas);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= func;
        in_ch.joint          <= j;
        in_ch.goal_angle     <= tgt;
        in_ch.target_valid   <= tok;
        in_ch.measured_angle <= meas;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        profile_sb.note_input(func, j, tgt, tok, meas);
        @(negedge i_clk);
    endtask

    // Withdraws the last item so it is not taken twice, then waits for
    // every expected result.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (profile_sb.pending_results.size() != 0) @(negedge i_clk);
        // Let the block settle before any register write.
        repeat (80) @(negedge i_clk);
    endtask

    // Writes one register; only called while no item is in flight.
    task automatic write_cfg(logic [1:0] idx, logic [31:0] value);
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        profile_sb.write_register(idx, value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_settings();
        case ($urandom_range(3))
            0: write_cfg(REG_VEL_LIMIT, $urandom_range(1, 2000000));
            1: write_cfg(REG_ACCEL_LIMIT, $urandom_range(1, 8000000));
            2: write_cfg(REG_TIME_STEP, $urandom_range(0, 200000));
            default: write_cfg(REG_MOTOR_ZERO, $urandom());
        endcase
    endtask

    // Random item: most items are runs of valid steps toward one target so
    // the profile ramps, cruises and settles; the rest are seeds, held
    // items and targets across the full range.
    task automatic random_item(logic [1:0] j, logic [31:0] tgt);
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            send_item(1'b0, j, tgt, 1'b1, $urandom());
        else if (pick < 88)
            send_item(1'b1, j, $urandom(), $urandom_range(1), $urandom());
        else if (pick < 94)
            send_item(1'b0, j, $urandom(), 1'b0, $urandom());
        else
            send_item(1'b0, j, $urandom(), 1'b1, $urandom());
    endtask

    // Receiver: samples the result at the rising edge and sets ready at the
    // falling edge, with random stalls and an optional long hold-off.
    initial begin
        t_profile_result got;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.joint_out        = out_ch.joint_out;
                got.motor_angle      = out_ch.motor_angle;
                got.profile_angle    = out_ch.profile_angle;
                got.profile_velocity = out_ch.profile_velocity;
                got.profile_accel    = out_ch.profile_accel;
                got.angle_error      = out_ch.angle_error;
                got.status           = out_ch.status;
                profile_sb.check_result(got);
            end
        end
    end

    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int phase;
        int n;
        int run_len;
        logic [1:0] j;
        logic [31:0] tgt;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.joint = '0;
        in_ch.goal_angle = '0;
        in_ch.target_valid = 1'b0;
        in_ch.measured_angle = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items at reset settings: seeds, holds, steps, extremes.
        send_item(1'b0, 2'd0, 32'h0001_0000, 1'b1, 32'h0);
        send_item(1'b0, 2'd0, 32'h0001_0000, 1'b1, 32'h7fff_ffff);
        send_item(1'b0, 2'd1, 32'h0, 1'b1, 32'h8000_0000);
        send_item(1'b0, 2'd2, 32'h7fff_ffff, 1'b0, 32'h8000_0000);
        send_item(1'b1, 2'd3, 32'h0, 1'b0, 32'h8000_0000);
        send_item(1'b0, 2'd3, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff);
        send_item(1'b1, 2'd2, 32'h0, 1'b1, 32'h7fff_ffff);
        send_item(1'b0, 2'd2, 32'h8000_0000, 1'b1, 32'hffff_ffff);
        send_item(1'b0, 2'd1, 32'h0000_0020, 1'b1, 32'h0);
        drain_results();

        // Extreme settings: zero limits and time step, then the largest limits
        // and a long time step to push the angle out of range.
        write_cfg(REG_VEL_LIMIT, 32'h0);
        write_cfg(REG_ACCEL_LIMIT, 32'h0);
        write_cfg(REG_TIME_STEP, 32'h0);
        write_cfg(REG_MOTOR_ZERO, 32'h8000_0000);
        send_item(1'b0, 2'd0, 32'h0000_0100, 1'b1, 32'h7fff_ffff);
        send_item(1'b0, 2'd0, 32'hffff_ff00, 1'b1, 32'h0);
        drain_results();
        write_cfg(REG_VEL_LIMIT, 32'h7fff_ffff);
        write_cfg(REG_ACCEL_LIMIT, 32'h7fff_ffff);
        write_cfg(REG_TIME_STEP, 32'h1ff_ffff);
        write_cfg(REG_MOTOR_ZERO, 32'h7fff_ffff);
        send_item(1'b1, 2'd1, 32'h0, 1'b1, 32'h7000_0000);
        send_item(1'b0, 2'd1, 32'h7fff_ffff, 1'b1, 32'h8000_0000);
        send_item(1'b1, 2'd2, 32'h0, 1'b1, 32'h9000_0000);
        send_item(1'b0, 2'd2, 32'h8000_0000, 1'b1, 32'h7fff_ffff);
        send_item(1'b0, 2'd2, 32'h8000_0000, 1'b1, 32'h0);
        drain_results();
        write_cfg(REG_TIME_STEP, 32'h100_0000);
        write_cfg(REG_VEL_LIMIT, 32'd205887);
        write_cfg(REG_ACCEL_LIMIT, 32'd823550);
        write_cfg(REG_TIME_STEP, 32'd16777);
        write_cfg(REG_MOTOR_ZERO, 32'd71488);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (phase == 4) hold_cycles = 600;
            n = 0;
            while (n < 145) begin
                j = $urandom_range(3);
                tgt = ($urandom_range(3) == 0) ? $urandom()
                                               : $urandom_range(0, 400000) - 200000;
                run_len = $urandom_range(1, 30);
                repeat (run_len) begin
                    random_item(j, tgt);
                    n++;
                end
            end
            drain_results();
            random_settings();
            if (phase == 7) begin
                write_cfg(REG_VEL_LIMIT, $urandom_range(1, 400000));
            end
        end

        drain_results();
        if (profile_sb.error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/jtp_pkg.sv
sv/jtp_in_if.sv
sv/jtp_out_if.sv
sv/jtp_cfg_if.sv
sv/joint_trapezoid_profile.sv
tb/tb_jtp_scoreboard.sv
tb/tb_joint_trapezoid_profile.sv
